FILE: hdl/pfu_pkg.sv
// Package with the field types, kind codes, register indexes and color tables of the particle update.
package pfu_pkg;

   localparam int POS_W   = 24;
   localparam int RAMP_W  = 16;
   localparam int COLOR_W = 8;
   localparam int KIND_W  = 3;
   localparam int TIME_W  = 32;
   localparam int FT_W    = 17;
   localparam int ADDR_W  = 2;
   localparam int DATA_W  = 200;
   localparam int WIDE_W  = 28;
   localparam int PROD_W  = 42;
   localparam int GRAV_W  = 14;

   typedef logic signed [POS_W-1:0]   fix_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic        [RAMP_W-1:0]  ramp_type;
   typedef logic        [COLOR_W-1:0] color_type;
   typedef logic        [KIND_W-1:0]  kind_type;
   typedef logic signed [TIME_W-1:0]  time_type;
   typedef logic        [FT_W-1:0]    ft_type;
   typedef logic        [GRAV_W-1:0]  grav_type;

   localparam kind_type KIND_STATIC   = 3'd0;
   localparam kind_type KIND_GRAV     = 3'd1;
   localparam kind_type KIND_SLOWGRAV = 3'd2;
   localparam kind_type KIND_FIRE     = 3'd3;
   localparam kind_type KIND_EXPLODE  = 3'd4;
   localparam kind_type KIND_EXPLODE2 = 3'd5;
   localparam kind_type KIND_BLOB     = 3'd6;
   localparam kind_type KIND_BLOB2    = 3'd7;

   localparam logic [ADDR_W-1:0] REG_FRAME_TIME = 2'd0;
   localparam logic [ADDR_W-1:0] REG_NOW_TIME   = 2'd1;

   localparam ft_type   FT_RESET      = 17'd3277;
   localparam ft_type   FT_MAX        = 17'd65536;
   localparam ramp_type RAMP_MAX      = 16'hFFFF;
   localparam ramp_type FIRE_LIMIT    = 16'h6000;
   localparam ramp_type EXPLODE_LIMIT = 16'h8000;
   localparam time_type DEAD_TIME     = -32'sd65536;
   localparam logic [3:0] FIRE_RATE     = 4'd5;
   localparam logic [3:0] EXPLODE_RATE  = 4'd10;
   localparam logic [3:0] EXPLODE2_RATE = 4'd15;
   localparam logic [5:0] GRAV_SCALE    = 6'd40;

   function automatic fix_type sat24(input wide_type v);
      fix_type r;
      if (v > wide_type'(24'sh7FFFFF)) begin
         r = 24'sh7FFFFF;
      end else if (v < -wide_type'(24'sh7FFFFF) - wide_type'(1)) begin
         r = -24'sh7FFFFF - 24'sd1;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   function automatic color_type fire_color(input logic [3:0] idx);
      color_type c;
      case (idx)
         4'd0:    c = 8'h6d;
         4'd1:    c = 8'h6b;
         4'd2:    c = 8'h06;
         4'd3:    c = 8'h05;
         4'd4:    c = 8'h04;
         default: c = 8'h03;
      endcase
      return c;
   endfunction

   function automatic color_type explode_color(input logic [2:0] idx);
      color_type c;
      case (idx)
         3'd0:    c = 8'h6f;
         3'd1:    c = 8'h6d;
         3'd2:    c = 8'h6b;
         3'd3:    c = 8'h69;
         3'd4:    c = 8'h67;
         3'd5:    c = 8'h65;
         3'd6:    c = 8'h63;
         default: c = 8'h61;
      endcase
      return c;
   endfunction

   function automatic color_type explode2_color(input logic [2:0] idx);
      color_type c;
      case (idx)
         3'd0:    c = 8'h6f;
         3'd1:    c = 8'h6e;
         3'd2:    c = 8'h6d;
         3'd3:    c = 8'h6c;
         3'd4:    c = 8'h6b;
         3'd5:    c = 8'h6a;
         3'd6:    c = 8'h68;
         default: c = 8'h66;
      endcase
      return c;
   endfunction

endpackage

FILE: hdl/particle_frame_update.sv
// Top level of the particle frame update: four-stage pipeline, one particle per cycle unless stalled.
//
// Each request on the req_ channel carries one particle record; the block returns exactly one
// updated record on the rsp_ channel for each request, in order. A particle whose death time is
// before now_time comes back with the expired flag set and all other fields unchanged.
// Registers are written through the csr_ channel (index 0 frame time, index 1 current time);
// csr_ready is always high, and writes are expected only while no request is in flight.
// A request accepted into the input register then passes the multiply stage, the rounding and
// saturation stage, and the output register, whose contents show on rsp_. The three
// velocity-by-frame-time multipliers set the stage depth. One request is accepted every cycle
// while the receiver keeps rsp_tready high.
// Every stage holds its own valid bit, so a stall on rsp_tready fills empty stages first and
// then holds the whole pipeline; nothing is dropped or repeated. req_tready goes low only when
// all four stages are full and the receiver is stalled.
// Synchronous reset empties the pipeline and sets frame time to 3277 and current time to zero.
module particle_frame_update (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, ramp_pos, colour, death_time
   input  logic [pfu_pkg::DATA_W-1:0] req_tdata,
   // kind
   input  logic [pfu_pkg::KIND_W-1:0] req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z, new_ramp_pos,
   // new_colour, new_death_time
   output logic [pfu_pkg::DATA_W-1:0] rsp_tdata,
   // expired, out_kind
   output logic [pfu_pkg::KIND_W:0]   rsp_tuser,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [pfu_pkg::ADDR_W-1:0] csr_addr,
   input  logic [31:0]               csr_wdata
);
   import pfu_pkg::*;

   ft_type   frame_time_ff;
   time_type now_time_ff;
   ft_type   ft;

   logic s0_en, s1_en, s2_en, s3_en;
   logic v0_ff, v1_ff, v2_ff, v3_ff;

   // Stage 0: input register.
   fix_type   s0_pos_ff [3];
   fix_type   s0_vel_ff [3];
   ramp_type  s0_ramp_ff;
   color_type s0_color_ff;
   kind_type  s0_kind_ff;
   time_type  s0_death_ff;

   // Stage 1: products, expiry, ramp step and gravity.
   fix_type   s1_pos_ff [3];
   fix_type   s1_vel_ff [3];
   prod_type  s1_prod_ff [3];
   ramp_type  s1_ramp_ff;
   color_type s1_color_ff;
   kind_type  s1_kind_ff;
   time_type  s1_death_ff;
   logic      s1_expired_ff;
   ramp_type  s1_step_ff;
   grav_type  s1_grav_ff;
   prod_type  s1_prod_in [3];
   logic      s1_expired_in;
   ramp_type  s1_step_in;
   grav_type  s1_grav_in;
   logic [3:0] rate;
   logic [FT_W+3:0] step_wide;
   logic [FT_W+5:0] grav_wide;

   // Stage 2: rounded updates with saturation.
   fix_type   s2_pos_ff [3];
   fix_type   s2_vel_ff [3];
   ramp_type  s2_ramp_ff;
   color_type s2_color_ff;
   kind_type  s2_kind_ff;
   time_type  s2_death_ff;
   logic      s2_expired_ff;
   logic      s2_ramp_end_ff;
   grav_type  s2_grav_ff;
   fix_type   s2_pos_in [3];
   fix_type   s2_vel_in [3];
   ramp_type  s2_ramp_in;
   logic      s2_ramp_end_in;
   logic [RAMP_W:0] ramp_sum;
   ramp_type  ramp_limit;

   // Stage 3: output register.
   fix_type   s3_pos_ff [3];
   fix_type   s3_vel_ff [3];
   ramp_type  s3_ramp_ff;
   color_type s3_color_ff;
   kind_type  s3_kind_ff;
   time_type  s3_death_ff;
   logic      s3_expired_ff;
   fix_type   s3_velz_in;
   color_type s3_color_in;
   time_type  s3_death_in;
   logic [3:0] ramp_idx;
   logic      ramp_kind;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_time_ff <= FT_RESET;
         now_time_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_addr)
            REG_FRAME_TIME: frame_time_ff <= csr_wdata[FT_W-1:0];
            REG_NOW_TIME:   now_time_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign ft = (frame_time_ff > FT_MAX) ? FT_MAX : frame_time_ff;

   assign s3_en      = !v3_ff || rsp_tready;
   assign s2_en      = !v2_ff || s3_en;
   assign s1_en      = !v1_ff || s2_en;
   assign s0_en      = !v0_ff || s1_en;
   assign req_tready = s0_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (s0_en) begin
            v0_ff <= req_tvalid;
         end
         if (s1_en) begin
            v1_ff <= v0_ff;
         end
         if (s2_en) begin
            v2_ff <= v1_ff;
         end
         if (s3_en) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s0_en) begin
         for (int i = 0; i < 3; i++) begin
            s0_pos_ff[i] <= req_tdata[POS_W*i +: POS_W];
            s0_vel_ff[i] <= req_tdata[POS_W*(3+i) +: POS_W];
         end
         s0_ramp_ff  <= req_tdata[6*POS_W +: RAMP_W];
         s0_color_ff <= req_tdata[6*POS_W+RAMP_W +: COLOR_W];
         s0_death_ff <= req_tdata[6*POS_W+RAMP_W+COLOR_W +: TIME_W];
         s0_kind_ff  <= req_tuser;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_prod_in[i] = prod_type'(s0_vel_ff[i]) * prod_type'($signed({1'b0, ft}));
      end
      s1_expired_in = s0_death_ff < now_time_ff;
      case (s0_kind_ff)
         KIND_FIRE:     rate = FIRE_RATE;
         KIND_EXPLODE:  rate = EXPLODE_RATE;
         KIND_EXPLODE2: rate = EXPLODE2_RATE;
         default:       rate = 4'd0;
      endcase
      step_wide  = ft * rate + (FT_W+4)'(8);
      s1_step_in = step_wide[RAMP_W+3:4];
      grav_wide  = ft * GRAV_SCALE + (FT_W+6)'(128);
      s1_grav_in = grav_wide[GRAV_W+7:8];
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_pos_ff     <= s0_pos_ff;
         s1_vel_ff     <= s0_vel_ff;
         s1_prod_ff    <= s1_prod_in;
         s1_ramp_ff    <= s0_ramp_ff;
         s1_color_ff   <= s0_color_ff;
         s1_kind_ff    <= s0_kind_ff;
         s1_death_ff   <= s0_death_ff;
         s1_expired_ff <= s1_expired_in;
         s1_step_ff    <= s1_step_in;
         s1_grav_ff    <= s1_grav_in;
      end
   end

   always_comb begin
      prod_type prod_r1;
      prod_type prod_r4;
      wide_type r1;
      wide_type r4;
      wide_type vel_w;
      for (int i = 0; i < 3; i++) begin
         prod_r1 = s1_prod_ff[i] + prod_type'(32768);
         prod_r4 = (s1_prod_ff[i] <<< 2) + prod_type'(32768);
         r1      = wide_type'($signed(prod_r1[PROD_W-2:16]));
         r4      = wide_type'($signed(prod_r4[PROD_W-1:16]));
         vel_w   = wide_type'(s1_vel_ff[i]);
         s2_pos_in[i] = s1_expired_ff ? s1_pos_ff[i]
                                      : sat24(wide_type'(s1_pos_ff[i]) + r1);
         s2_vel_in[i] = s1_vel_ff[i];
         if (!s1_expired_ff) begin
            case (s1_kind_ff)
               KIND_EXPLODE, KIND_BLOB: s2_vel_in[i] = sat24(vel_w + r4);
               KIND_EXPLODE2:           s2_vel_in[i] = sat24(vel_w - r1);
               KIND_BLOB2: begin
                  if (i < 2) begin
                     s2_vel_in[i] = sat24(vel_w - r4);
                  end
               end
               default: ;
            endcase
         end
      end
      ramp_sum   = {1'b0, s1_ramp_ff} + {1'b0, s1_step_ff};
      ramp_limit = (s1_kind_ff == KIND_FIRE) ? FIRE_LIMIT : EXPLODE_LIMIT;
      if (s1_expired_ff) begin
         s2_ramp_in = s1_ramp_ff;
      end else if (ramp_sum[RAMP_W]) begin
         s2_ramp_in = RAMP_MAX;
      end else begin
         s2_ramp_in = ramp_sum[RAMP_W-1:0];
      end
      s2_ramp_end_in = s2_ramp_in >= ramp_limit;
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_pos_ff      <= s2_pos_in;
         s2_vel_ff      <= s2_vel_in;
         s2_ramp_ff     <= s2_ramp_in;
         s2_ramp_end_ff <= s2_ramp_end_in;
         s2_color_ff    <= s1_color_ff;
         s2_kind_ff     <= s1_kind_ff;
         s2_death_ff    <= s1_death_ff;
         s2_expired_ff  <= s1_expired_ff;
         s2_grav_ff     <= s1_grav_ff;
      end
   end

   always_comb begin
      s3_velz_in  = s2_vel_ff[2];
      s3_color_in = s2_color_ff;
      s3_death_in = s2_death_ff;
      ramp_idx    = s2_ramp_ff[RAMP_W-1:RAMP_W-4];
      ramp_kind   = (s2_kind_ff == KIND_FIRE) || (s2_kind_ff == KIND_EXPLODE) ||
                    (s2_kind_ff == KIND_EXPLODE2);
      if (!s2_expired_ff) begin
         if (s2_kind_ff == KIND_FIRE) begin
            s3_velz_in = sat24(wide_type'(s2_vel_ff[2]) + wide_type'(s2_grav_ff));
         end else if (s2_kind_ff != KIND_STATIC) begin
            s3_velz_in = sat24(wide_type'(s2_vel_ff[2]) - wide_type'(s2_grav_ff));
         end
         if (ramp_kind) begin
            if (s2_ramp_end_ff) begin
               s3_death_in = DEAD_TIME;
            end else begin
               case (s2_kind_ff)
                  KIND_FIRE:    s3_color_in = fire_color(ramp_idx);
                  KIND_EXPLODE: s3_color_in = explode_color(ramp_idx[2:0]);
                  default:      s3_color_in = explode2_color(ramp_idx[2:0]);
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_pos_ff     <= s2_pos_ff;
         s3_vel_ff[0]  <= s2_vel_ff[0];
         s3_vel_ff[1]  <= s2_vel_ff[1];
         s3_vel_ff[2]  <= s3_velz_in;
         s3_ramp_ff    <= s2_ramp_ff;
         s3_color_ff   <= s3_color_in;
         s3_kind_ff    <= s2_kind_ff;
         s3_death_ff   <= s3_death_in;
         s3_expired_ff <= s2_expired_ff;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {s3_death_ff, s3_color_ff, s3_ramp_ff,
                        s3_vel_ff[2], s3_vel_ff[1], s3_vel_ff[0],
                        s3_pos_ff[2], s3_pos_ff[1], s3_pos_ff[0]};
   assign rsp_tuser  = {s3_kind_ff, s3_expired_ff};

endmodule

FILE: test/particle_frame_update_test.sv
// Self-checking testbench for the particle frame update pipeline.
module particle_frame_update_test;
   import pfu_pkg::*;

   localparam logic [ADDR_W-1:0] REG_UNUSED_A = 2'd2;
   localparam logic [ADDR_W-1:0] REG_UNUSED_B = 2'd3;
   localparam longint DAMP_SCALE   = 4;
   localparam int     QUIET_LIMIT  = 5000;
   localparam int     DRAIN_CYCLES = 8;
   localparam int     PRINT_LIMIT  = 50;
   localparam logic [5:0][COLOR_W-1:0] FIRE_COLORS =
      {8'h03, 8'h04, 8'h05, 8'h06, 8'h6b, 8'h6d};
   localparam logic [7:0][COLOR_W-1:0] EXPLODE_COLORS =
      {8'h61, 8'h63, 8'h65, 8'h67, 8'h69, 8'h6b, 8'h6d, 8'h6f};
   localparam logic [7:0][COLOR_W-1:0] EXPLODE2_COLORS =
      {8'h66, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f};

   typedef struct packed {
      time_type  death_time;
      color_type colour;
      ramp_type  ramp_pos;
      fix_type   vel_z;
      fix_type   vel_y;
      fix_type   vel_x;
      fix_type   pos_z;
      fix_type   pos_y;
      fix_type   pos_x;
   } particle_body;

   typedef struct {
      logic         expired;
      kind_type     kind;
      particle_body body;
   } particle_update;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [DATA_W-1:0]   req_tdata;
   logic [KIND_W-1:0]   req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [DATA_W-1:0]   rsp_tdata;
   logic [KIND_W:0]     rsp_tuser;
   logic                csr_valid;
   logic                csr_ready;
   logic [ADDR_W-1:0]   csr_addr;
   logic [31:0]         csr_wdata;

   ft_type              frame_time_reg;
   time_type            now_time_reg;
   particle_update      pending_updates[$];
   int                  mismatches;
   int                  quiet_cycles;
   logic                steady;

   particle_frame_update u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint round_q16(input longint a, input longint b);
      return (a * b + 64'sd32768) >>> 16;
   endfunction

   function automatic fix_type clamp_pos(input longint v);
      if (v > 64'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (v < -64'sd8388608) begin
         return fix_type'(24'h800000);
      end
      return fix_type'(v);
   endfunction

   function automatic particle_update advance_particle(input particle_body b, input kind_type k);
      particle_update u;
      longint ft, grav, dvel, rate, ramp, limit;
      longint pos[3], vel[3], nvel[3];
      int unsigned idx;
      u.expired = b.death_time < now_time_reg;
      u.kind = k;
      u.body = b;
      ft = (frame_time_reg > FT_MAX) ? longint'(FT_MAX) : longint'(frame_time_reg);
      grav = (ft * longint'(GRAV_SCALE) + 128) >>> 8;
      dvel = ft * DAMP_SCALE;
      pos[0] = b.pos_x;
      pos[1] = b.pos_y;
      pos[2] = b.pos_z;
      vel[0] = b.vel_x;
      vel[1] = b.vel_y;
      vel[2] = b.vel_z;
      if (!u.expired) begin
         for (int i = 0; i < 3; i++) begin
            pos[i] = clamp_pos(pos[i] + round_q16(vel[i], ft));
            nvel[i] = vel[i];
         end
         rate = 0;
         limit = 0;
         case (k)
            KIND_FIRE: begin
               rate = FIRE_RATE;
               limit = FIRE_LIMIT;
            end
            KIND_EXPLODE: begin
               rate = EXPLODE_RATE;
               limit = EXPLODE_LIMIT;
            end
            KIND_EXPLODE2: begin
               rate = EXPLODE2_RATE;
               limit = EXPLODE_LIMIT;
            end
            default: begin
            end
         endcase
         if (rate != 0) begin
            ramp = longint'(b.ramp_pos) + ((ft * rate + 8) >>> 4);
            if (ramp > longint'(RAMP_MAX)) begin
               ramp = RAMP_MAX;
            end
            u.body.ramp_pos = ramp_type'(ramp);
            if (ramp >= limit) begin
               u.body.death_time = DEAD_TIME;
            end else begin
               idx = int'(ramp >>> 12);
               if (k == KIND_FIRE) begin
                  u.body.colour = FIRE_COLORS[(idx < 6) ? idx : 5];
               end else if (k == KIND_EXPLODE) begin
                  u.body.colour = EXPLODE_COLORS[idx % 8];
               end else begin
                  u.body.colour = EXPLODE2_COLORS[idx % 8];
               end
            end
         end
         if (k == KIND_EXPLODE || k == KIND_BLOB) begin
            for (int i = 0; i < 3; i++) begin
               nvel[i] = clamp_pos(vel[i] + round_q16(vel[i], dvel));
            end
         end else if (k == KIND_EXPLODE2) begin
            for (int i = 0; i < 3; i++) begin
               nvel[i] = clamp_pos(vel[i] - round_q16(vel[i], ft));
            end
         end else if (k == KIND_BLOB2) begin
            for (int i = 0; i < 2; i++) begin
               nvel[i] = clamp_pos(vel[i] - round_q16(vel[i], dvel));
            end
         end
         if (k == KIND_FIRE) begin
            nvel[2] = clamp_pos(nvel[2] + grav);
         end else if (k != KIND_STATIC) begin
            nvel[2] = clamp_pos(nvel[2] - grav);
         end
         u.body.pos_x = fix_type'(pos[0]);
         u.body.pos_y = fix_type'(pos[1]);
         u.body.pos_z = fix_type'(pos[2]);
         u.body.vel_x = fix_type'(nvel[0]);
         u.body.vel_y = fix_type'(nvel[1]);
         u.body.vel_z = fix_type'(nvel[2]);
      end
      return u;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < PRINT_LIMIT) begin
         $display("mismatch on %s: got %h, expected %h", field, got, want);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin : check_responses
      particle_body   got;
      particle_update want;
      got = rsp_tdata;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_updates.size() == 0) begin
            report_mismatch("response with no request pending", rsp_tuser, 0);
         end else begin
            want = pending_updates.pop_front();
            if (rsp_tuser[0] !== want.expired)
               report_mismatch("expired", rsp_tuser[0], want.expired);
            if (rsp_tuser[KIND_W:1] !== want.kind)
               report_mismatch("out_kind", rsp_tuser[KIND_W:1], want.kind);
            if (got.pos_x !== want.body.pos_x)
               report_mismatch("new_pos_x", got.pos_x, want.body.pos_x);
            if (got.pos_y !== want.body.pos_y)
               report_mismatch("new_pos_y", got.pos_y, want.body.pos_y);
            if (got.pos_z !== want.body.pos_z)
               report_mismatch("new_pos_z", got.pos_z, want.body.pos_z);
            if (got.vel_x !== want.body.vel_x)
               report_mismatch("new_vel_x", got.vel_x, want.body.vel_x);
            if (got.vel_y !== want.body.vel_y)
               report_mismatch("new_vel_y", got.vel_y, want.body.vel_y);
            if (got.vel_z !== want.body.vel_z)
               report_mismatch("new_vel_z", got.vel_z, want.body.vel_z);
            if (got.ramp_pos !== want.body.ramp_pos)
               report_mismatch("new_ramp_pos", got.ramp_pos, want.body.ramp_pos);
            if (got.colour !== want.body.colour)
               report_mismatch("new_colour", got.colour, want.body.colour);
            if (got.death_time !== want.body.death_time)
               report_mismatch("new_death_time", got.death_time, want.body.death_time);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 31);
   end

   task automatic send_particle(input particle_body b, input kind_type k);
      while (!steady && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= k;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_updates.push_back(advance_particle(b, k));
      @(negedge clock);
   endtask

   task automatic send_simple(input kind_type k, input fix_type pos, input fix_type vel,
                              input ramp_type ramp, input time_type death);
      particle_body b;
      b.pos_x = pos;
      b.pos_y = ~pos;
      b.pos_z = pos;
      b.vel_x = vel;
      b.vel_y = ~vel;
      b.vel_z = vel;
      b.ramp_pos = ramp;
      b.colour = color_type'($urandom);
      b.death_time = death;
      send_particle(b, k);
   endtask

   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (pending_updates.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (addr == REG_FRAME_TIME) begin
         frame_time_reg = data[FT_W-1:0];
      end else if (addr == REG_NOW_TIME) begin
         now_time_reg = data;
      end
      @(negedge clock);
   endtask

   task automatic set_regs(input logic [31:0] frame_time, input logic [31:0] now_time);
      wait_until_drained();
      write_csr(REG_FRAME_TIME, frame_time);
      write_csr(REG_NOW_TIME, now_time);
      csr_valid <= 1'b0;
   endtask

   function automatic fix_type random_fix();
      case ($urandom_range(3))
         0: return fix_type'($urandom);
         1: return fix_type'(int'($urandom_range(8191)) - 4096);
         2: return $urandom_range(1) ? 24'sh7FFFFF : fix_type'(24'h800000);
         default: return fix_type'(int'($urandom_range(2097151)) - 1048576);
      endcase
   endfunction

   task automatic send_random_particle();
      particle_body b;
      b.pos_x = random_fix();
      b.pos_y = random_fix();
      b.pos_z = random_fix();
      b.vel_x = random_fix();
      b.vel_y = random_fix();
      b.vel_z = random_fix();
      case ($urandom_range(2))
         0: b.ramp_pos = ramp_type'($urandom);
         1: b.ramp_pos = ($urandom_range(1) ? FIRE_LIMIT : EXPLODE_LIMIT) -
                         ramp_type'($urandom_range(3000));
         default: b.ramp_pos = ramp_type'($urandom_range(4095));
      endcase
      b.colour = color_type'($urandom);
      case ($urandom_range(4))
         0: b.death_time = time_type'($urandom);
         1: b.death_time = now_time_reg - time_type'($urandom_range(5000, 1));
         default: b.death_time = now_time_reg + time_type'($urandom_range(1000000));
      endcase
      send_particle(b, kind_type'($urandom_range(7)));
   endtask

   task automatic test_default_frame_time();
      send_simple(KIND_GRAV, 24'sh001000, 24'sh010000, 16'h0000, 32'sh7FFFFFFF);
      send_simple(KIND_FIRE, 24'sh000400, 24'sh002000, 16'h0100, 32'sh00010000);
   endtask

   task automatic test_each_kind();
      set_regs(32'd6554, 32'd0);
      for (int k = KIND_STATIC; k <= KIND_BLOB2; k++) begin
         send_simple(kind_type'(k), 24'sh012345, fix_type'(24'sh00ABCD - k * 24'sh001111),
                     16'h1800, 32'sh00100000);
      end
   endtask

   task automatic test_expiry();
      set_regs(FT_RESET, 32'h80000000);
      send_simple(KIND_GRAV, 24'sh000100, 24'sh000100, 16'h0000, 32'sh80000000);
      set_regs(FT_RESET, 32'h7FFFFFFF);
      send_simple(KIND_FIRE, 24'sh000200, 24'sh000300, 16'h0400, 32'sh7FFFFFFE);
      send_simple(KIND_EXPLODE, 24'sh000200, 24'sh000300, 16'h0400, 32'sh7FFFFFFF);
   endtask

   task automatic test_saturation();
      set_regs(FT_MAX, 32'd0);
      send_simple(KIND_STATIC, 24'sh7FFFFF, 24'sh7FFFFF, 16'h0000, 32'sh00000000);
      send_simple(KIND_EXPLODE, fix_type'(24'h800000), fix_type'(24'h800000),
                  16'h0000, 32'sh00000000);
      send_simple(KIND_BLOB2, 24'sh7FFFFF, fix_type'(24'h800000), 16'h0000, 32'sh00000000);
      send_simple(KIND_FIRE, 24'sh7FFFF0, 24'sh7FFFFF, 16'hFFFF, 32'sh00000000);
   endtask

   task automatic test_ramp_end();
      set_regs(FT_RESET, 32'd0);
      send_simple(KIND_FIRE, 24'sh000100, 24'sh000100, RAMP_MAX, 32'sh00200000);
      send_simple(KIND_FIRE, 24'sh000100, 24'sh000100, FIRE_LIMIT - 16'd1, 32'sh00200000);
      send_simple(KIND_EXPLODE, 24'sh000100, 24'sh000100, 16'h0000, 32'sh00200000);
      send_simple(KIND_EXPLODE2, 24'sh000100, 24'sh000100, EXPLODE_LIMIT - 16'd3073,
                  32'sh00200000);
   endtask

   task automatic test_frame_time_limits();
      // All 32 bits set: only 17 bits are kept, and the value is then capped at one second.
      set_regs(32'hFFFFFFFF, 32'd0);
      send_simple(KIND_EXPLODE, 24'sh001234, 24'sh043210, 16'h2000, 32'sh00001000);
      set_regs(32'd0, 32'd0);
      send_simple(KIND_FIRE, 24'sh001234, 24'sh043210, 16'h2000, 32'sh00001000);
   endtask

   task automatic test_unknown_index();
      set_regs(32'd4000, 32'd0);
      write_csr(REG_UNUSED_A, 32'h00001234);
      write_csr(REG_UNUSED_B, 32'h80005678);
      csr_valid <= 1'b0;
      send_simple(KIND_BLOB, 24'sh004000, 24'sh020000, 16'h0000, 32'sh00001000);
   endtask

   task automatic test_random_traffic();
      logic [31:0] frame_time;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: frame_time = FT_RESET;
            1: frame_time = FT_MAX;
            2: frame_time = $urandom_range(65536);
            3: frame_time = 32'h0001FFFF;
            4: frame_time = 32'd0;
            default: frame_time = $urandom;
         endcase
         set_regs(frame_time, (phase == 0) ? 32'd0 : $urandom);
         steady = (phase == 3);
         for (int n = 0; n < 175; n++) begin
            send_random_particle();
            if (phase == 2 && n == 80) begin
               wait_until_drained();
            end
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      rsp_tready     = 1'b0;
      csr_valid      = 1'b0;
      csr_addr       = '0;
      csr_wdata      = '0;
      frame_time_reg = FT_RESET;
      now_time_reg   = '0;
      mismatches     = 0;
      quiet_cycles   = 0;
      steady         = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_default_frame_time();
      test_each_kind();
      test_expiry();
      test_saturation();
      test_ramp_end();
      test_frame_time_limits();
      test_unknown_index();
      test_random_traffic();

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_updates.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: particle_frame_update.f
hdl/pfu_pkg.sv
hdl/particle_frame_update.sv
test/particle_frame_update_test.sv
